// ===== hw/rtl/srr_pkg.sv =====
// Shared types, widths and codes for the spectral relative RMSE core.
`timescale 1ns / 1ps

package srr_pkg;

    localparam int W_SAMPLE   = 16;
    localparam int W_BANDCFG  = 9;
    localparam int W_PIXCFG   = 21;
    localparam int W_BANDIDX  = 8;
    localparam int W_PIXIDX   = 20;
    localparam int W_SQSUM    = 41;
    localparam int W_REFSUM   = 24;
    localparam int W_TOTAL    = 52;
    localparam int W_OPND     = 52;
    localparam int W_REM      = 25;
    localparam int W_ROOT     = 21;
    localparam int W_NUM      = 46;
    localparam int W_STEP     = 6;
    localparam int W_RATIO    = 32;
    localparam int W_CFG_IDX  = 8;
    localparam int W_CFG_DATA = 21;

    localparam int MAX_BANDS  = 256;
    localparam int MAX_PIXELS = 1048576;
    localparam int SQRT_STEPS = 21;
    localparam int DIV_STEPS  = 52;

    localparam logic [W_CFG_IDX-1:0] CFG_BAND_COUNT  = 8'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_PIXEL_COUNT = 8'd1;

    localparam logic [W_RATIO-1:0] RATIO_MAX = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

// ===== hw/rtl/srr_iter_unit.sv =====
// Shared shift-and-subtract unit: restoring divide or digit-by-digit square root.
`timescale 1ns / 1ps

module srr_iter_unit
    import srr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  unit_req_t           req,
    input  logic [W_OPND-1:0]   operand,
    input  logic [W_REFSUM-1:0] divisor,
    output unit_rsp_t           rsp,
    output logic [W_OPND-1:0]   result
);

    logic [W_OPND-1:0]   acc_reg;
    logic [W_REM-1:0]    rem_reg;
    logic [W_OPND-1:0]   res_reg;
    logic [W_REFSUM-1:0] dvs_reg;
    logic [W_STEP-1:0]   step_reg;
    unit_op_t            op_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [W_REM-1:0]    shifted;
    logic [W_REM-1:0]    trial;
    logic [W_REM:0]      diff;
    logic                fits;

    // The radicand takes two bits a step, the dividend one.
    always_comb
    begin
        case (op_reg)
            OP_SQRT:
            begin
                shifted = {rem_reg[W_REM-3:0], acc_reg[W_OPND-1 -: 2]};
                trial   = {res_reg[W_REM-3:0], 2'b01};
            end
            OP_DIV:
            begin
                shifted = {rem_reg[W_REM-2:0], acc_reg[W_OPND-1]};
                trial   = {1'b0, dvs_reg};
            end
            default:
            begin
                shifted = '0;
                trial   = '0;
            end
        endcase
        diff = {1'b0, shifted} - {1'b0, trial};
        fits = ~diff[W_REM];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            res_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            op_reg   <= OP_DIV;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                res_reg  <= '0;
                busy_reg <= 1'b1;
                if (req.op == OP_SQRT)
                begin
                    // Left-align the radicand so that its top pair leads.
                    acc_reg  <= operand << (W_OPND - 2 * SQRT_STEPS);
                    step_reg <= W_STEP'(SQRT_STEPS);
                end
                else
                begin
                    acc_reg  <= operand;
                    step_reg <= W_STEP'(DIV_STEPS);
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[W_REM-1:0] : shifted;
                res_reg  <= {res_reg[W_OPND-2:0], fits};
                acc_reg  <= (op_reg == OP_SQRT) ? (acc_reg << 2) : (acc_reg << 1);
                step_reg <= step_reg - W_STEP'(1);
                if (step_reg == W_STEP'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

// ===== hw/rtl/spectral_relative_rmse_core.sv =====
// Top level of the spectral relative RMSE core: accumulation, sequencing and ports.
`timescale 1ns / 1ps
// A band word that does not close its pixel is accumulated and the core stays ready for the next word.
// Closing a pixel with a positive reference sum passes through the shared unit and the scaling:
// a 21-step square root, the band scaling, then a 52-step divide. A non-positive sum skips all three.
// The last pixel of an image adds the mean divide and a load of the output register.
// The output register holds a result while the next image streams in.
// Asynchronous active-low reset clears all sums and counters and sets both counts to one.

module spectral_relative_rmse_core
    import srr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // ref_sample[15:0], cmp_sample[31:16]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // mean_error[31:0]
    output logic [0:0]            m_axis_tuser,   // clipped[0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [W_CFG_IDX-1:0]  cfg_index,
    input  logic [W_CFG_DATA-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROOT  = 5'b00010,
        ST_RATIO = 5'b00100,
        ST_MEAN  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t                  state_reg;
    logic [W_BANDCFG-1:0]    band_count_reg;
    logic [W_PIXCFG-1:0]     pixel_count_reg;
    logic [W_BANDIDX-1:0]    band_index_reg;
    logic [W_PIXIDX-1:0]     pixel_index_reg;
    logic [W_SQSUM-1:0]      square_sum_reg;
    logic signed [W_REFSUM-1:0] reference_sum_reg;
    logic [W_TOTAL-1:0]      error_total_reg;
    logic                    clip_seen_reg;
    logic                    last_reg;
    logic [W_BANDCFG-1:0]    bands_reg;
    logic [W_PIXCFG-1:0]     pixels_reg;
    logic [W_NUM-1:0]        num_reg;
    logic                    start_reg;
    logic                    out_valid_reg;
    logic [W_RATIO-1:0]      out_data_reg;
    logic                    out_clip_reg;

    logic [W_BANDCFG-1:0]    bands;
    logic [W_PIXCFG-1:0]     pixels;
    logic signed [W_SAMPLE:0] diff;
    logic [W_SAMPLE:0]       abs_diff;
    logic [2*W_SAMPLE-1:0]   sq;
    logic [W_SQSUM-1:0]      sq_next;
    logic signed [W_REFSUM-1:0] ref_next;
    logic                    ref_pos;
    logic                    pixel_end;
    logic                    image_end;
    logic                    accept;

    unit_req_t               unit_req;
    unit_rsp_t               unit_rsp;
    logic [W_OPND-1:0]       unit_operand;
    logic [W_REFSUM-1:0]     unit_divisor;
    logic [W_OPND-1:0]       unit_result;
    logic [W_ROOT+W_BANDCFG-1:0] scaled;
    logic                    ratio_sat;
    logic [W_RATIO-1:0]      ratio;
    logic                    mean_sat;

    // A count of zero means one; counts above the maximum clamp to it.
    always_comb
    begin
        if (band_count_reg == '0)
            bands = W_BANDCFG'(1);
        else if (band_count_reg > W_BANDCFG'(MAX_BANDS))
            bands = W_BANDCFG'(MAX_BANDS);
        else
            bands = band_count_reg;

        if (pixel_count_reg == '0)
            pixels = W_PIXCFG'(1);
        else if (pixel_count_reg > W_PIXCFG'(MAX_PIXELS))
            pixels = W_PIXCFG'(MAX_PIXELS);
        else
            pixels = pixel_count_reg;
    end

    always_comb
    begin
        diff     = $signed({s_axis_tdata[W_SAMPLE-1], s_axis_tdata[W_SAMPLE-1:0]})
                 - $signed({s_axis_tdata[2*W_SAMPLE-1], s_axis_tdata[2*W_SAMPLE-1:W_SAMPLE]});
        abs_diff = diff[W_SAMPLE] ? (~diff + (W_SAMPLE+1)'(1)) : diff;
        sq       = {{W_SAMPLE{1'b0}}, abs_diff[W_SAMPLE-1:0]}
                 * {{W_SAMPLE{1'b0}}, abs_diff[W_SAMPLE-1:0]};
        sq_next  = square_sum_reg + {{(W_SQSUM-2*W_SAMPLE){1'b0}}, sq};
        ref_next = reference_sum_reg
                 + {{(W_REFSUM-W_SAMPLE){s_axis_tdata[W_SAMPLE-1]}},
                    s_axis_tdata[W_SAMPLE-1:0]};
        ref_pos  = ~ref_next[W_REFSUM-1] && (ref_next != '0);
        pixel_end = !(({1'b0, band_index_reg} + W_BANDCFG'(1)) < bands);
        image_end = !(({1'b0, pixel_index_reg} + W_PIXCFG'(1)) < pixels);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        unit_req.start = start_reg;
        case (state_reg)
            ST_ROOT:
            begin
                unit_req.op  = OP_SQRT;
                unit_operand = {{(W_OPND-W_SQSUM){1'b0}}, square_sum_reg};
                unit_divisor = '0;
            end
            ST_RATIO:
            begin
                unit_req.op  = OP_DIV;
                unit_operand = {{(W_OPND-W_NUM){1'b0}}, num_reg};
                unit_divisor = reference_sum_reg;
            end
            ST_MEAN:
            begin
                unit_req.op  = OP_DIV;
                unit_operand = error_total_reg;
                unit_divisor = {{(W_REFSUM-W_PIXCFG){1'b0}}, pixels_reg};
            end
            default:
            begin
                unit_req.op  = OP_DIV;
                unit_operand = '0;
                unit_divisor = '0;
            end
        endcase
    end

    srr_iter_unit u_unit
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (unit_req),
        .operand (unit_operand),
        .divisor (unit_divisor),
        .rsp     (unit_rsp),
        .result  (unit_result)
    );

    always_comb
    begin
        scaled    = {{W_BANDCFG{1'b0}}, unit_result[W_ROOT-1:0]}
                  * {{W_ROOT{1'b0}}, bands_reg};
        ratio_sat = |unit_result[W_OPND-1:W_RATIO];
        ratio     = ratio_sat ? RATIO_MAX : unit_result[W_RATIO-1:0];
        mean_sat  = |unit_result[W_OPND-1:W_RATIO];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            band_count_reg    <= W_BANDCFG'(1);
            pixel_count_reg   <= W_PIXCFG'(1);
            band_index_reg    <= '0;
            pixel_index_reg   <= '0;
            square_sum_reg    <= '0;
            reference_sum_reg <= '0;
            error_total_reg   <= '0;
            clip_seen_reg     <= 1'b0;
            last_reg          <= 1'b0;
            bands_reg         <= W_BANDCFG'(1);
            pixels_reg        <= W_PIXCFG'(1);
            num_reg           <= '0;
            start_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BAND_COUNT)
                    band_count_reg <= cfg_data[W_BANDCFG-1:0];
                else if (cfg_index == CFG_PIXEL_COUNT)
                    pixel_count_reg <= cfg_data;
            end

            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!pixel_end)
                        begin
                            band_index_reg    <= band_index_reg + W_BANDIDX'(1);
                            square_sum_reg    <= sq_next;
                            reference_sum_reg <= ref_next;
                        end
                        else
                        begin
                            band_index_reg  <= '0;
                            last_reg        <= image_end;
                            bands_reg       <= bands;
                            pixels_reg      <= pixels;
                            pixel_index_reg <= image_end ? '0
                                             : pixel_index_reg + W_PIXIDX'(1);
                            if (ref_pos)
                            begin
                                square_sum_reg    <= sq_next;
                                reference_sum_reg <= ref_next;
                                state_reg         <= ST_ROOT;
                                start_reg         <= 1'b1;
                            end
                            else
                            begin
                                square_sum_reg    <= '0;
                                reference_sum_reg <= '0;
                                if (image_end)
                                begin
                                    state_reg <= ST_MEAN;
                                    start_reg <= 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (unit_rsp.done)
                    begin
                        num_reg   <= {scaled, 16'b0};
                        state_reg <= ST_RATIO;
                        start_reg <= 1'b1;
                    end
                end
                ST_RATIO:
                begin
                    if (unit_rsp.done)
                    begin
                        error_total_reg   <= error_total_reg
                                           + {{(W_TOTAL-W_RATIO){1'b0}}, ratio};
                        clip_seen_reg     <= clip_seen_reg | ratio_sat;
                        square_sum_reg    <= '0;
                        reference_sum_reg <= '0;
                        if (last_reg)
                        begin
                            state_reg <= ST_MEAN;
                            start_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_MEAN:
                begin
                    if (unit_rsp.done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // The quotient stays in the unit until the output word is free.
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg   <= 1'b1;
                        error_total_reg <= '0;
                        clip_seen_reg   <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= mean_sat ? RATIO_MAX : unit_result[W_RATIO-1:0];
            out_clip_reg <= clip_seen_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_clip_reg;

    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !unit_rsp.busy)
        else $error("shared unit busy while the core accepts samples");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_rsp.done |-> (state_reg == ST_ROOT || state_reg == ST_RATIO
                           || state_reg == ST_MEAN))
        else $error("shared unit finished outside a wait state");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        unit_req.start |-> !unit_rsp.busy)
        else $error("shared unit restarted while running");

endmodule
